// File: design/ptte_pkg.sv
// ----------------------------------------------------------------------------
// Pen tablet packet decoder package
// Shared types and constants for the packet front end, queue and event back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptte_pkg;

    localparam int PACKET_BYTES = 9;
    localparam int POS_W        = 4;
    localparam int STORED_BYTES = 7;

    localparam logic [1:0] CFG_LEAD_MASK  = 2'd0;
    localparam logic [1:0] CFG_LEAD_VALUE = 2'd1;
    localparam logic [1:0] CFG_TOUCH_MASK = 2'd2;

    localparam logic [7:0] RST_LEAD_MASK  = 8'h80;
    localparam logic [7:0] RST_LEAD_VALUE = 8'h80;
    localparam logic [7:0] RST_TOUCH_MASK = 8'h10;

    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [2:0] CODE_X        = 3'd0;
    localparam logic [2:0] CODE_Y        = 3'd1;
    localparam logic [2:0] CODE_PRESSURE = 3'd2;
    localparam logic [2:0] CODE_TOUCH    = 3'd3;
    localparam logic [2:0] CODE_STYLUS   = 3'd4;
    localparam logic [2:0] CODE_STYLUS2  = 3'd5;
    localparam logic [2:0] CODE_REPORT   = 3'd6;

    localparam int PKT_FIFO_DEPTH = 2;
    localparam int PKT_PTR_W      = $clog2(PKT_FIFO_DEPTH);
    localparam int PKT_CNT_W      = $clog2(PKT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [9:0]  pressure;
        logic [2:0]  keys;
    } t_pkt;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [15:0] value;
        logic        last;
    } t_event;

endpackage

`default_nettype wire

// File: design/ptte_front.sv
// ----------------------------------------------------------------------------
// Pen tablet packet front end
// Synchronizes on the lead byte, collects packet bytes, drops touch packets
// and hands each complete pen packet to the packet queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptte_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic                i_cfg_valid,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_pkt_full,
    output logic                     o_stall,
    output logic                     o_pkt_push,
    output ptte_pkg::t_pkt           o_pkt
);
    import ptte_pkg::*;

    localparam logic [POS_W-1:0] POS_FIRST = '0;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] POS_SKIP  = POS_W'(PACKET_BYTES);

    logic [7:0]       r_lead_mask;
    logic [7:0]       r_lead_value;
    logic [7:0]       r_touch_mask;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_bytes [STORED_BYTES];
    logic             touch_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_mask  <= RST_LEAD_MASK;
            r_lead_value <= RST_LEAD_VALUE;
            r_touch_mask <= RST_TOUCH_MASK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEAD_MASK:  r_lead_mask  <= i_cfg_data;
                CFG_LEAD_VALUE: r_lead_value <= i_cfg_data;
                CFG_TOUCH_MASK: r_touch_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign touch_pkt = (r_bytes[0] & r_touch_mask) == r_touch_mask;

    always_comb begin
        priority if (r_pos >= POS_SKIP) begin
            n_pos = POS_FIRST;
        end else if (r_pos == POS_FIRST) begin
            n_pos = ((i_rx_byte & r_lead_mask) == r_lead_value) ? POS_W'(1) : POS_FIRST;
        end else if (r_pos == POS_LAST) begin
            n_pos = touch_pkt ? POS_SKIP : POS_FIRST;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    for (genvar g = 0; g < STORED_BYTES; g++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (i_accept && r_pos == POS_W'(g)) begin
                r_bytes[g] <= i_rx_byte;
            end
        end
    end

    assign o_stall    = (r_pos == POS_LAST) && i_pkt_full;
    assign o_pkt_push = i_accept && (r_pos == POS_LAST) && !touch_pkt;

    assign o_pkt.x        = {r_bytes[1][6:0], r_bytes[2][6:0], r_bytes[6][6:5]};
    assign o_pkt.y        = {r_bytes[3][6:0], r_bytes[4][6:0], r_bytes[6][4:3]};
    assign o_pkt.pressure = {r_bytes[6][2:0], r_bytes[5][6:0]};
    assign o_pkt.keys     = r_bytes[0][2:0];

endmodule

`default_nettype wire

// File: design/ptte_pkt_fifo.sv
// ----------------------------------------------------------------------------
// Pen tablet packet queue
// Short first-in first-out queue of decoded packets between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptte_pkt_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ptte_pkg::t_pkt i_data,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ptte_pkg::t_pkt      o_data
);
    import ptte_pkg::*;

    t_pkt                 r_mem [PKT_FIFO_DEPTH];
    logic [PKT_PTR_W-1:0] r_wr_ptr;
    logic [PKT_PTR_W-1:0] r_rd_ptr;
    logic [PKT_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = r_count == PKT_CNT_W'(PKT_FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PKT_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PKT_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + PKT_CNT_W'(1);
                2'b01:   r_count <= r_count - PKT_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/ptte_back.sv
// ----------------------------------------------------------------------------
// Pen tablet event back end
// Steps through the oldest queued packet's events into an output register,
// one event a cycle while it is empty or popped, skipping unchanged keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptte_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_pkt_empty,
    input  wire ptte_pkg::t_pkt i_pkt,
    output logic                o_pkt_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ptte_pkg::t_event    o_event
);
    import ptte_pkg::*;

    localparam logic [2:0] STEP_X        = 3'd0;
    localparam logic [2:0] STEP_Y        = 3'd1;
    localparam logic [2:0] STEP_PRESSURE = 3'd2;
    localparam logic [2:0] STEP_TOUCH    = 3'd3;
    localparam logic [2:0] STEP_STYLUS   = 3'd4;
    localparam logic [2:0] STEP_STYLUS2  = 3'd5;
    localparam logic [2:0] STEP_REPORT   = 3'd6;

    logic [2:0] r_step;
    logic [2:0] r_prev_keys;
    logic       r_out_valid;
    t_event     r_out;
    t_event     ev;
    logic       emit;
    logic       slot_free;
    logic       advance;
    logic       load;
    logic [2:0] key_diff;

    assign key_diff = i_pkt.keys ^ r_prev_keys;

    always_comb begin
        ev   = '0;
        emit = 1'b0;
        unique case (r_step)
            STEP_X: begin
                ev   = '{KIND_AXIS, CODE_X, i_pkt.x, 1'b0};
                emit = 1'b1;
            end
            STEP_Y: begin
                ev   = '{KIND_AXIS, CODE_Y, i_pkt.y, 1'b0};
                emit = 1'b1;
            end
            STEP_PRESSURE: begin
                ev   = '{KIND_AXIS, CODE_PRESSURE, {6'd0, i_pkt.pressure}, 1'b0};
                emit = 1'b1;
            end
            STEP_TOUCH: begin
                ev   = '{KIND_KEY, CODE_TOUCH, {15'd0, i_pkt.keys[0]}, 1'b0};
                emit = key_diff[0];
            end
            STEP_STYLUS: begin
                ev   = '{KIND_KEY, CODE_STYLUS, {15'd0, i_pkt.keys[1]}, 1'b0};
                emit = key_diff[1];
            end
            STEP_STYLUS2: begin
                ev   = '{KIND_KEY, CODE_STYLUS2, {15'd0, i_pkt.keys[2]}, 1'b0};
                emit = key_diff[2];
            end
            STEP_REPORT: begin
                ev   = '{KIND_REPORT, CODE_REPORT, 16'd0, 1'b1};
                emit = 1'b1;
            end
            default: begin
                ev   = '0;
                emit = 1'b0;
            end
        endcase
    end

    assign slot_free = !r_out_valid || i_pop;
    assign advance   = !i_pkt_empty && (slot_free || !emit);
    assign load      = advance && emit;
    assign o_pkt_pop = advance && (r_step == STEP_REPORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_X;
            r_prev_keys <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step <= (r_step >= STEP_REPORT) ? STEP_X : r_step + 3'd1;
            end
            if (o_pkt_pop) begin
                r_prev_keys <= i_pkt.keys;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= ev;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_event = r_out;

endmodule

`default_nettype wire

// File: design/pen_tablet_packet_to_events.sv
// ----------------------------------------------------------------------------
// Pen tablet packet to events
// Decodes serial pen tablet packets into axis, key and report events.
//
//   Channel   Handshake            Payload
//   input     push / full          i_rx_byte
//   result    empty / pop          o_event_kind, o_event_code, o_event_value,
//                                  o_last_event
//   config    i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// One byte is taken per cycle unless full is high. A pen packet yields
// four to seven events, one per cycle from the event register while it is
// empty or popped; an unchanged key's step emits none. The two-entry packet
// queue lets the front keep taking bytes while events drain; full rises
// only on a packet's final byte when the queue holds two packets. Reset is
// synchronous and clears position, key history, queue and output state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pen_tablet_packet_to_events (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_event_kind,
    output logic [2:0]       o_event_code,
    output logic [15:0]      o_event_value,
    output logic             o_last_event,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import ptte_pkg::*;

    logic   accept;
    logic   stall;
    logic   pkt_push;
    t_pkt   pkt_in;
    logic   pkt_full;
    logic   pkt_empty;
    logic   pkt_pop;
    t_pkt   pkt_out;
    t_event ev;

    assign o_cfg_ready = 1'b1;
    assign full        = stall;
    assign accept      = push && !stall;

    ptte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pkt_full  (pkt_full),
        .o_stall     (stall),
        .o_pkt_push  (pkt_push),
        .o_pkt       (pkt_in)
    );

    ptte_pkt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pkt_push),
        .i_data  (pkt_in),
        .i_pop   (pkt_pop),
        .o_full  (pkt_full),
        .o_empty (pkt_empty),
        .o_data  (pkt_out)
    );

    ptte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_empty (pkt_empty),
        .i_pkt       (pkt_out),
        .o_pkt_pop   (pkt_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_event     (ev)
    );

    assign o_event_kind  = ev.kind;
    assign o_event_code  = ev.code;
    assign o_event_value = ev.value;
    assign o_last_event  = ev.last;

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Pen tablet packet decoder testbench
// Streams serial bytes into the decoder and compares every event it emits
// against a cycle-free prediction of the packet framing, touch filtering and
// key-change tracking. Covers edge bytes, sync and touch settings at their
// extremes, broken packets and random back-pressure on both queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ptte_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 400000;

    class event_scoreboard;
        logic [7:0] lead_mask;
        logic [7:0] lead_value;
        logic [7:0] touch_mask;
        int         position;
        logic [7:0] packet_bytes [PACKET_BYTES];
        logic [2:0] prev_keys;
        t_event     expected_events [$];
        int         errors;
        int         bytes_in;
        int         pen_packets;
        int         touch_packets;
        int         checked;
        int         reg_writes;

        function new();
            lead_mask = RST_LEAD_MASK;
            lead_value = RST_LEAD_VALUE;
            touch_mask = RST_TOUCH_MASK;
            position = 0;
            prev_keys = 3'b000;
            errors = 0;
            bytes_in = 0;
            pen_packets = 0;
            touch_packets = 0;
            checked = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void add_event(logic [1:0] kind, logic [2:0] code, logic [15:0] value,
                                logic last);
            t_event e;
            e.kind = kind;
            e.code = code;
            e.value = value;
            e.last = last;
            expected_events.push_back(e);
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            reg_writes++;
            case (idx)
                CFG_LEAD_MASK: lead_mask = data;
                CFG_LEAD_VALUE: lead_value = data;
                CFG_TOUCH_MASK: touch_mask = data;
                default: ;
            endcase
        endfunction

        function void decode_packet();
            logic [15:0] x;
            logic [15:0] y;
            logic [9:0]  pressure;
            logic [2:0]  keys;
            x = {packet_bytes[1][6:0], packet_bytes[2][6:0], packet_bytes[6][6:5]};
            y = {packet_bytes[3][6:0], packet_bytes[4][6:0], packet_bytes[6][4:3]};
            pressure = {packet_bytes[6][2:0], packet_bytes[5][6:0]};
            keys = packet_bytes[0][2:0];
            add_event(KIND_AXIS, CODE_X, x, 1'b0);
            add_event(KIND_AXIS, CODE_Y, y, 1'b0);
            add_event(KIND_AXIS, CODE_PRESSURE, {6'd0, pressure}, 1'b0);
            for (int i = 0; i < 3; i++) begin
                if (keys[i] != prev_keys[i]) begin
                    add_event(KIND_KEY, CODE_TOUCH + 3'(i), {15'd0, keys[i]}, 1'b0);
                end
            end
            add_event(KIND_REPORT, CODE_REPORT, 16'd0, 1'b1);
            prev_keys = keys;
            pen_packets++;
        endfunction

        function void note_byte(logic [7:0] b);
            bytes_in++;
            if (position >= PACKET_BYTES) begin
                position = 0;
            end else begin
                packet_bytes[position] = b;
                if (position == 0) begin
                    if ((b & lead_mask) == lead_value) begin
                        position = 1;
                    end
                end else if (position == PACKET_BYTES - 1) begin
                    if ((packet_bytes[0] & touch_mask) == touch_mask) begin
                        position = PACKET_BYTES;
                        touch_packets++;
                    end else begin
                        position = 0;
                        decode_packet();
                    end
                end else begin
                    position++;
                end
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_event(logic [1:0] kind, logic [2:0] code, logic [15:0] value, logic last);
            t_event e;
            checked++;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d code %0d value %h last %0d",
                                 kind, code, value, last));
            end else begin
                e = expected_events.pop_front();
                if (kind !== e.kind || code !== e.code || value !== e.value
                        || last !== e.last) begin
                    report($sformatf("got kind %0d code %0d value %h last %0d, want %0d %0d %h %0d",
                                     kind, code, value, last, e.kind, e.code, e.value, e.last));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_event_kind;
    logic [2:0]  o_event_code;
    logic [15:0] o_event_value;
    logic        o_last_event;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    event_scoreboard sb;
    bit send_idle = 1'b1;
    bit sink_idle = 1'b1;
    int cycle_count = 0;

    pen_tablet_packet_to_events uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_event_kind  (o_event_kind),
        .o_event_code  (o_event_code),
        .o_event_value (o_event_value),
        .o_last_event  (o_last_event),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_event(o_event_kind, o_event_code, o_event_value, o_last_event);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin : sink
        int n;
        pop <= 1'b0;
        forever begin
            n = sink_idle ? gap_len() : 0;
            repeat (n) begin
                @(posedge i_clk);
                pop <= 1'b0;
            end
            n = $urandom_range(1, 24);
            repeat (n) begin
                @(posedge i_clk);
                pop <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        push <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(b);
        gap = send_idle ? gap_len() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        while (sb.position != 0) send_byte(rand_byte());
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] lm, input logic [7:0] lv,
                                 input logic [7:0] tm);
        set_reg(CFG_LEAD_MASK, lm);
        set_reg(CFG_LEAD_VALUE, lv);
        set_reg(CFG_TOUCH_MASK, tm);
    endtask

    task automatic random_packets(input int n_items);
        int sent;
        int r;
        int k;
        logic [7:0] b0;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_byte(rand_byte());
                sent++;
            end else begin
                b0 = (rand_byte() & ~sb.lead_mask) | (sb.lead_value & sb.lead_mask);
                if (r < 30) begin
                    b0 = b0 | sb.touch_mask;
                end
                send_byte(b0);
                k = (r < 36) ? $urandom_range(1, 7) : PACKET_BYTES - 1;
                repeat (k) send_byte(rand_byte());
                sent += k + 1;
            end
            if ($urandom_range(0, 99) < 3) begin
                wait_drained();
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] m;
        sb = new();
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_rx_byte <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_LEAD_MASK;
        i_cfg_data <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unsynchronized lead bytes, a full-scale pen packet with all keys down,
        // a touch packet with its swallowed byte, then an all-zero pen packet.
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h87);
        repeat (PACKET_BYTES - 1) send_byte(8'hFF);
        send_byte(8'h90);
        repeat (PACKET_BYTES - 1) send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        repeat (PACKET_BYTES - 1) send_byte(8'h00);

        random_packets(40);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        random_packets(25);
        wait_drained();
        random_packets(15);
        send_idle = 1'b1;
        sink_idle = 1'b1;

        apply_setting(8'h00, 8'h00, 8'hFF);
        random_packets(40);
        set_reg(CFG_UNUSED, 8'($urandom));
        random_packets(15);

        // A zero touch mask discards every packet.
        apply_setting(8'hFF, 8'hFF, 8'h00);
        random_packets(25);

        apply_setting(8'hF0, 8'hA0, 8'h0C);
        random_packets(35);

        repeat (2) begin
            m = 8'($urandom);
            apply_setting(m, 8'($urandom) & m, 8'($urandom_range(1, 255)));
            random_packets(25);
        end

        apply_setting(RST_LEAD_MASK, RST_LEAD_VALUE, RST_TOUCH_MASK);
        send_idle = 1'b0;
        random_packets(25);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d events never arrived", sb.pending()));
        end
        $display("summary: %0d bytes sent, %0d pen packets decoded, %0d touch packets dropped",
                 sb.bytes_in, sb.pen_packets, sb.touch_packets);
        $display("summary: %0d events checked across %0d register writes",
                 sb.checked, sb.reg_writes);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
